/* sv/u8f_pkg.sv */
`timescale 1ns / 1ps
package u8f_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned MAX_SEQ = 4;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
  localparam logic [BYTE_W-1:0] MASK_2 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3 = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4 = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_CONT = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;

  // One validated sequence, bytes in stream order, last_idx = length - 1.
  typedef struct packed {
    logic [MAX_SEQ-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]               last_idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    priority if (b <= ASCII_MAX)         len = LEN_ONE;
    else if ((b & MASK_2) == LEAD_2)     len = LEN_TWO;
    else if ((b & MASK_3) == LEAD_3)     len = LEN_THREE;
    else if ((b & MASK_4) == LEAD_4)     len = LEN_FOUR;
    else                                 len = LEN_NONE;
    return len;
  endfunction

endpackage

/* sv/u8f_front.sv */
`timescale 1ns / 1ps
module u8f_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_take,
  input  logic [7:0]            in_byte,
  input  logic                  stream_end,
  output logic                  push_valid,
  output u8f_pkg::job_t         push_data
);
  import u8f_pkg::*;

  logic [BYTE_W-1:0] held_bytes [3];
  logic [LEN_W-1:0]  seq_length;
  logic [IDX_W-1:0]  bytes_taken;
  logic              seq_ok;

  logic [LEN_W-1:0]  len;
  logic              ok_next;
  logic              closing;
  logic [IDX_W-1:0]  last_idx;

  always_comb begin
    len      = lead_length(in_byte);
    ok_next  = seq_ok & ((in_byte & MASK_CONT) == CONT_MARK);
    closing  = (seq_length != LEN_NONE) &&
               (({1'b0, bytes_taken} + LEN_ONE) >= seq_length);
    last_idx = (seq_length == LEN_NONE) ? '0 : bytes_taken;
    push_valid = in_take &&
                 (((seq_length == LEN_NONE) && (len == LEN_ONE)) || (closing && ok_next));
    push_data.last_idx = last_idx;
    for (int k = 0; k < MAX_SEQ - 1; k++) begin
      push_data.bytes[k] = (IDX_W'(k) < last_idx) ? held_bytes[k] : in_byte;
    end
    push_data.bytes[MAX_SEQ-1] = in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length  <= LEN_NONE;
      bytes_taken <= '0;
      seq_ok      <= 1'b1;
    end else if (in_take) begin
      if (stream_end || closing) begin
        // close out the sequence; a partial one is dropped
        seq_length  <= LEN_NONE;
        bytes_taken <= '0;
        seq_ok      <= 1'b1;
      end else if (seq_length == LEN_NONE) begin
        if (len > LEN_ONE) begin
          seq_length  <= len;
          bytes_taken <= IDX_W'(1);
          seq_ok      <= 1'b1;
        end
      end else begin
        bytes_taken <= bytes_taken + IDX_W'(1);
        seq_ok      <= ok_next;
      end
    end
  end

  // held bytes carry no reset: each entry is written before it is read
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (seq_length == LEN_NONE) begin
        held_bytes[0] <= in_byte;
      end else if (!closing && (bytes_taken != 2'd3)) begin
        held_bytes[bytes_taken] <= in_byte;
      end
    end
  end

endmodule

/* sv/u8f_queue.sv */
`timescale 1ns / 1ps
module u8f_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  u8f_pkg::job_t     push_data,
  input  logic              pop_ready,
  output logic              pop_valid,
  output u8f_pkg::job_t     pop_data,
  output u8f_pkg::q_stat_t  stat
);
  import u8f_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_valid  = !stat.empty;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && !stat.full;
  assign do_pop     = pop_ready && !stat.empty;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

/* sv/u8f_back.sv */
`timescale 1ns / 1ps
module u8f_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  input  u8f_pkg::job_t  pop_data,
  output logic           pop_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           run_last
);
  import u8f_pkg::*;

  job_t             cur;
  logic [IDX_W-1:0] idx;
  logic             busy;
  logic             done;

  assign out_valid = busy;
  assign out_byte  = cur.bytes[idx];
  assign run_last  = (idx == cur.last_idx);
  assign done      = busy && out_ready && run_last;
  assign pop_ready = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop_ready) begin
      busy <= pop_valid;
      idx  <= '0;
    end else if (busy && out_ready) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) cur <= pop_data;
  end

endmodule

/* sv/utf8_invalid_sequence_filter.sv */
`timescale 1ns / 1ps
// Flow: a completed sequence is pushed into the job queue, then loaded into
// the back end, which drains its bytes one per cycle while m_tready is high.
// Throughput: one input byte per cycle; the front stalls only when the job
// queue of QUEUE_DEPTH sequences is full.
// Reset: rst is synchronous, active high; it empties the queue, closes any
// open sequence and idles the output.
module utf8_invalid_sequence_filter #(
  parameter int unsigned QUEUE_DEPTH = 4  // sequences buffered, 2 to 32
) (
  input  logic       clk,
  input  logic       rst,
  // input stream: tdata[7:0] = in_byte, tlast = stream_end
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // [7:0] in_byte
  input  logic       s_tlast,     // stream_end
  // output stream: tdata[7:0] = out_byte, tlast = run_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // [7:0] out_byte
  output logic       m_tlast      // run_last
);
  import u8f_pkg::*;

  logic    in_take;
  logic    push_valid;
  job_t    push_data;
  logic    pop_valid;
  logic    pop_ready;
  job_t    pop_data;
  q_stat_t q_stat;

  // Hold off input whenever the queue is full, whether or not this byte
  // would close a sequence; that keeps ready free of the byte's value.
  assign s_tready = !q_stat.full;
  assign in_take  = s_tvalid && s_tready;

  // Front: classify each byte, track the open sequence, and push one job
  // per well-formed sequence. Bad leads and broken sequences are dropped.
  u8f_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_take    (in_take),
    .in_byte    (s_tdata),
    .stream_end (s_tlast),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Queue of finished sequences between the two sides.
  u8f_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .stat       (q_stat)
  );

  // Back: serialize each job onto the output, marking the final byte.
  u8f_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .run_last  (m_tlast)
  );

  // Queue cannot read as both full and empty.
  a_stat_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // A byte inside a sequence is always followed by the next one without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("output gap inside a sequence");

  // A job pushed into an empty queue with an idle back end reaches the output.
  a_fast_path: assert property (@(posedge clk) disable iff (rst)
    (push_valid && q_stat.empty && !m_tvalid) |-> ##2 m_tvalid)
    else $error("pushed sequence did not reach the output");

  // Nothing is popped unless the queue holds a job.
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (pop_ready && pop_valid) |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

/* test/tb_utf8_invalid_sequence_filter.sv */
`timescale 1ns / 1ps
// Testbench for utf8_invalid_sequence_filter.
// A directed part covers ASCII bytes, each multibyte sequence length, lone
// invalid lead bytes, bad continuation bytes and sequences cut short by
// stream_end. A random part follows, made mostly of well-formed sequences with
// random content, with broken sequences and noise mixed in. One test holds the
// output side off for a long stretch so the internal queue fills up and the
// input stalls, and the last test runs with neither side idling.
// A monitor predicts the filtered bytes for every accepted request. A checker
// compares each output byte against the oldest expected byte.
module tb_utf8_invalid_sequence_filter;
  import u8f_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 12;
  localparam int LIMIT       = 400000;
  localparam int RANDOM_REQS = 320;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
  } text_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;   // [7:0] in_byte
  logic              s_tlast = 1'b0; // stream_end
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;        // [7:0] out_byte
  logic              m_tlast;        // run_last

  // Open sequence, as the filter sees it.
  logic [BYTE_W-1:0] held [3];
  logic [LEN_W-1:0]  open_len;
  logic [IDX_W-1:0]  taken;
  logic              seq_ok;

  text_byte_t        expected_bytes [$];
  int                errors    = 0;
  int                cycles    = 0;
  int                hold_left = 0;
  bit                tx_idle   = 1'b1;
  bit                rx_idle   = 1'b1;

  utf8_invalid_sequence_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [LEN_W-1:0] seq_len_of(input logic [BYTE_W-1:0] b);
    casez (b)
      8'b0???????: return LEN_ONE;
      8'b110?????: return LEN_TWO;
      8'b1110????: return LEN_THREE;
      8'b11110???: return LEN_FOUR;
      default:     return LEN_NONE;
    endcase
  endfunction

  task automatic close_seq();
    held[0]  = '0;
    held[1]  = '0;
    held[2]  = '0;
    open_len = LEN_NONE;
    taken    = '0;
    seq_ok   = 1'b1;
  endtask

  // Advance the filter state by one request and queue the bytes it releases.
  task automatic predict_filter(input logic [BYTE_W-1:0] b, input logic stream_end);
    logic [LEN_W-1:0] len;
    logic             ok_next;
    if (open_len == LEN_NONE) begin
      len = seq_len_of(b);
      if (len == LEN_ONE) begin
        expected_bytes.push_back('{b, 1'b1});
      end else if (len != LEN_NONE) begin
        held[0]  = b;
        open_len = len;
        taken    = 2'd1;
        seq_ok   = 1'b1;
      end
    end else begin
      // Any byte counts toward the length; only its shape decides validity.
      ok_next = seq_ok & (b[7:6] == 2'b10);
      if ({1'b0, taken} + 3'd1 >= open_len) begin
        if (ok_next) begin
          for (int k = 0; k < int'(taken); k++)
            expected_bytes.push_back('{held[k], 1'b0});
          expected_bytes.push_back('{b, 1'b1});
        end
        close_seq();
      end else begin
        held[taken] = b;
        taken       = taken + 2'd1;
        seq_ok      = ok_next;
      end
    end
    // Drop whatever is still open once the stream ends.
    if (stream_end)
      close_seq();
  endtask

  initial close_seq();

  // Predict on every accepted request.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      predict_filter(s_tdata, s_tlast);
  end

  // Check every accepted output byte against the oldest expectation.
  always @(posedge clk) begin
    text_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %02h (run_last %0b)", m_tdata, m_tlast);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
          errors++;
        end
        if (m_tlast !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, m_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready  <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        if (rx_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 17);
        if (stall_left > 0) begin
          m_tready <= 1'b0;
          stall_left--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until accepted; valid stays high afterwards.
  task automatic send_byte(input logic [7:0] b, input logic stream_end);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= stream_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // A byte whose top bits are anything but the continuation mark.
  function automatic logic [7:0] non_cont_byte();
    logic [1:0] top;
    top = 2'($urandom_range(0, 2));
    if (top == 2'b10)
      top = 2'b11;
    return {top, 6'($urandom)};
  endfunction

  function automatic logic [LEN_W-1:0] rand_len(input int lo);
    case ($urandom_range(lo, 4))
      1:       return LEN_ONE;
      2:       return LEN_TWO;
      3:       return LEN_THREE;
      default: return LEN_FOUR;
    endcase
  endfunction

  // Send one sequence with random content. bad_pos > 0 corrupts that
  // continuation; end_pos >= 0 marks stream_end there and cuts the rest.
  task automatic send_seq(input logic [LEN_W-1:0] len, input int bad_pos,
                          input int end_pos, inout int sent);
    logic [7:0] b;
    for (int i = 0; i < int'(len); i++) begin
      if (i == 0) begin
        case (len)
          LEN_ONE:   b = {1'b0, 7'($urandom)};
          LEN_TWO:   b = {3'b110, 5'($urandom)};
          LEN_THREE: b = {4'b1110, 4'($urandom)};
          default:   b = {5'b11110, 3'($urandom)};
        endcase
      end else if (i == bad_pos) begin
        b = non_cont_byte();
      end else begin
        b = cont_byte();
      end
      send_byte(b, i == end_pos);
      sent++;
      if (i == end_pos)
        break;
    end
  endtask

  // Wait for every expected byte, then let the pipeline settle.
  task automatic drain();
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_multibyte();
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // Stray continuation and the reserved F8..FF leads are dropped alone.
  task automatic test_invalid_lead();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b0);
  endtask

  // A bad continuation is still swallowed into the sequence.
  task automatic test_bad_continuation();
    send_byte(8'hC2, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_stream_end();
    // open sequence cut short by the end of the stream
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    send_byte(8'h41, 1'b1);
    // a byte carrying stream_end that completes a sequence still emits it
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b1);
  endtask

  // Hold the output off while requests keep coming so the queue fills.
  task automatic test_backpressure();
    int sent;
    sent     = 0;
    tx_idle  = 1'b0;
    // drop valid so the last request is not offered again while waiting
    s_tvalid <= 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 30; i++)
      send_seq(rand_len(1), 0, -1, sent);
    tx_idle = 1'b1;
  endtask

  task automatic test_random();
    int sent;
    int pick;
    logic [LEN_W-1:0] len;
    sent = 0;
    while (sent < RANDOM_REQS) begin
      // now and then switch to a stretch without idling, and back
      if ($urandom_range(0, 39) == 0) begin
        tx_idle = ~tx_idle;
        rx_idle = ~rx_idle;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = rand_len(1);
        send_seq(len, 0,
                 ($urandom_range(0, 24) == 0) ? $urandom_range(0, int'(len) - 1) : -1,
                 sent);
      end else if (pick < 85) begin
        len = rand_len(2);
        send_seq(len, $urandom_range(1, int'(len) - 1),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(len) - 1) : -1,
                 sent);
      end else if (pick < 93) begin
        send_byte(($urandom_range(0, 1) == 1) ? cont_byte() : {5'b11111, 3'($urandom)},
                  1'b0);
        sent++;
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 9) == 0);
        sent++;
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_streaming();
    int sent;
    sent    = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 20; i++)
      send_seq(rand_len(1), 0, -1, sent);
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii();
    test_multibyte();
    test_invalid_lead();
    test_bad_continuation();
    test_stream_end();
    test_backpressure();
    test_random();
    test_streaming();

    s_tvalid <= 1'b0;
    drain();

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
sv/u8f_pkg.sv
sv/u8f_front.sv
sv/u8f_queue.sv
sv/u8f_back.sv
sv/utf8_invalid_sequence_filter.sv
test/tb_utf8_invalid_sequence_filter.sv
